// ===== src/bounded_position_deque_assert.svh =====
// Assertion macros for the bounded position deque.
// Needs clk and arst_n in the scope of each use.
`ifndef BOUNDED_POSITION_DEQUE_ASSERT_SVH
`define BOUNDED_POSITION_DEQUE_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define BPD_ASSERT_IMPL(lbl, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error("bpd assertion failed: same-cycle check");
// next-cycle implication
`define BPD_ASSERT_NEXT(lbl, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error("bpd assertion failed: next-cycle check");
`else
`define BPD_ASSERT_IMPL(lbl, ant, cons)
`define BPD_ASSERT_NEXT(lbl, ant, cons)
`endif

`endif

// ===== src/bpd_pkg.sv =====
// Shared types for the bounded position deque.
// No dependencies.
package bpd_pkg;

	localparam int CNT_W = 9;

	typedef enum logic [2:0] {
		CMD_INS_HEAD = 3'd0,
		CMD_INS_TAIL = 3'd1,
		CMD_RM_HEAD  = 3'd2,
		CMD_RM_TAIL  = 3'd3,
		CMD_RD_HEAD  = 3'd4,
		CMD_RD_TAIL  = 3'd5,
		CMD_RD_INDEX = 3'd6,
		CMD_COUNT    = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_BAD_INDEX = 2'd3
	} status_t;

	// Control part of a result, one stage behind the accepted command.
	typedef struct packed {
		logic             vld;    // result strobe
		logic             rd;     // read hit: entry comes from the RAM
		status_t          status;
		logic [CNT_W-1:0] count;  // entries after the command
	} res_ctl_t;

endpackage

// ===== src/bpd_ram.sv =====
// Generic single-port synchronous RAM, registered read.
// No dependencies.
module bpd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else begin
			rdata <= mem[addr];
		end
	end

endmodule

// ===== src/bpd_ctrl.sv =====
// Ring pointer and count control for the bounded position deque.
// Depends on bpd_pkg and bounded_position_deque_assert.svh.
`include "bounded_position_deque_assert.svh"

module bpd_ctrl #(
	parameter int CAPACITY   = 256,
	parameter int COORD_BITS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        acc,
	input  bpd_pkg::cmd_t               cmd,
	input  logic [7:0]                  pos_x,
	input  logic [7:0]                  pos_y,
	input  logic [7:0]                  pos_symbol,
	input  logic [7:0]                  item_index,
	output logic                        ram_we,
	output logic [$clog2(CAPACITY)-1:0] ram_addr,
	output logic [2*COORD_BITS+7:0]     ram_wdata,
	output bpd_pkg::res_ctl_t           res_s1
);
	import bpd_pkg::*;

	localparam int PW   = $clog2(CAPACITY);
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > 8) ? CW : 8;
	localparam int SW   = CMPW + 1;

	logic [PW-1:0] head_q, head_d;
	logic [CW-1:0] count_q, count_d;
	logic          full, empty, idx_ok;
	status_t       status;
	logic          rd_hit;

	// head + offset, offset never above CAPACITY: one compare-subtract
	function automatic logic [PW-1:0] wrap(input logic [SW-1:0] s);
		logic [SW-1:0] r;
		r = (s >= SW'(CAPACITY)) ? s - SW'(CAPACITY) : s;
		return r[PW-1:0];
	endfunction

	assign full   = (count_q == CW'(CAPACITY));
	assign empty  = (count_q == '0);
	assign idx_ok = (CMPW'(item_index) < CMPW'(count_q));

	assign ram_wdata = {pos_symbol, COORD_BITS'(pos_x), COORD_BITS'(pos_y)};

	always_comb begin
		head_d   = head_q;
		count_d  = count_q;
		status   = ST_OK;
		rd_hit   = 1'b0;
		ram_we   = 1'b0;
		ram_addr = head_q;
		case (cmd)
			CMD_INS_HEAD: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					head_d   = (head_q == '0) ? PW'(CAPACITY - 1) : head_q - 1'b1;
					count_d  = count_q + 1'b1;
					ram_we   = acc;
					ram_addr = head_d;
				end
			end
			CMD_INS_TAIL: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					count_d  = count_q + 1'b1;
					ram_we   = acc;
					ram_addr = wrap(SW'(head_q) + SW'(count_q));
				end
			end
			CMD_RM_HEAD: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					head_d  = (head_q == PW'(CAPACITY - 1)) ? '0 : head_q + 1'b1;
					count_d = count_q - 1'b1;
				end
			end
			CMD_RM_TAIL: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					count_d = count_q - 1'b1;
				end
			end
			CMD_RD_HEAD: begin
				if (empty) begin
					status = ST_BAD_INDEX;
				end else begin
					rd_hit = 1'b1;
				end
			end
			CMD_RD_TAIL: begin
				if (empty) begin
					status = ST_BAD_INDEX;
				end else begin
					rd_hit   = 1'b1;
					ram_addr = wrap(SW'(head_q) + SW'(count_q) - 1'b1);
				end
			end
			CMD_RD_INDEX: begin
				if (!idx_ok) begin
					status = ST_BAD_INDEX;
				end else begin
					rd_hit   = 1'b1;
					ram_addr = wrap(SW'(head_q) + SW'(item_index));
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q        <= '0;
			count_q       <= '0;
			res_s1.vld    <= 1'b0;
			res_s1.rd     <= 1'b0;
			res_s1.status <= ST_OK;
			res_s1.count  <= '0;
		end else begin
			res_s1.vld <= acc;
			if (acc) begin
				head_q        <= head_d;
				count_q       <= count_d;
				res_s1.rd     <= rd_hit;
				res_s1.status <= status;
				res_s1.count  <= CNT_W'(count_d);
			end
		end
	end

	`BPD_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CW'(CAPACITY))
	`BPD_ASSERT_NEXT(a_insert_grows, ram_we, count_q == CW'($past(count_q) + 1'b1))
	`BPD_ASSERT_NEXT(a_rd_hold, acc && cmd >= CMD_RD_HEAD, {head_q, count_q} == $past({head_q, count_q}))

endmodule

// ===== src/bounded_position_deque.sv =====
// Top level of the bounded position deque: control, entry RAM, result stage.
// Depends on bpd_pkg, bpd_ctrl, bpd_ram and bounded_position_deque_assert.svh.
`include "bounded_position_deque_assert.svh"

// A command is taken at every clock edge where start is high and busy is low;
// busy never rises, so one command per cycle is sustained. Each command gives
// exactly one result, shown for one cycle with done high, in the cycle after
// the command was taken, as the registered read of the entry RAM returns data
// for it. The receiver cannot stall, so results must be captured
// whenever done is high. Inserts write the RAM in the accept cycle and reads
// issue their address in theirs, so a read straight after an insert already
// sees the new entry. The RAM needs no clearing pass after reset; only slots
// inside the list are ever read, and those were all written.
module bounded_position_deque #(
	parameter int CAPACITY   = 256,
	parameter int COORD_BITS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [2:0] cmd,
	input  logic [7:0] pos_x,
	input  logic [7:0] pos_y,
	input  logic [7:0] pos_symbol,
	input  logic [7:0] item_index,
	output logic       done,
	output logic [7:0] out_x,
	output logic [7:0] out_y,
	output logic [7:0] out_symbol,
	output logic       out_valid,
	output logic [8:0] entry_count,
	output logic [1:0] status
);
	import bpd_pkg::*;

	localparam int PW = $clog2(CAPACITY);
	localparam int EW = 2 * COORD_BITS + 8;

	logic          acc;
	logic          ram_we;
	logic [PW-1:0] ram_addr;
	logic [EW-1:0] ram_wdata, ram_rdata;
	res_ctl_t      res_s1;

	// every cycle is free for a new transfer
	assign busy = 1'b0;
	assign acc  = start && !busy;

	bpd_ctrl #(
		.CAPACITY   (CAPACITY),
		.COORD_BITS (COORD_BITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.acc        (acc),
		.cmd        (cmd_t'(cmd)),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_symbol (pos_symbol),
		.item_index (item_index),
		.ram_we     (ram_we),
		.ram_addr   (ram_addr),
		.ram_wdata  (ram_wdata),
		.res_s1     (res_s1)
	);

	// entry layout: symbol on top, then x, then y
	bpd_ram #(
		.WIDTH (EW),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// Result stage: RAM data shows only for a read hit, cleared otherwise.
	assign done        = res_s1.vld;
	assign out_valid   = res_s1.vld && res_s1.rd;
	assign out_symbol  = out_valid ? ram_rdata[EW-1 -: 8] : '0;
	assign out_x       = out_valid ? 8'(ram_rdata[2*COORD_BITS-1:COORD_BITS]) : '0;
	assign out_y       = out_valid ? 8'(ram_rdata[COORD_BITS-1:0]) : '0;
	assign entry_count = res_s1.count;
	assign status      = res_s1.status;

	`BPD_ASSERT_NEXT(a_one_result, acc, done)
	`BPD_ASSERT_IMPL(a_valid_means_ok, out_valid, done && status == ST_OK)

endmodule

// ===== tb/tb_bounded_position_deque.sv =====
// Self-checking testbench for bounded_position_deque: directed end cases, fill and drain,
// then a random walk over the list level, all checked against a shadow copy of the ring.
// Depends on bpd_pkg and the bounded_position_deque RTL.
`timescale 1ns / 100ps

module tb_bounded_position_deque;
	import bpd_pkg::*;

	localparam int DEPTH       = 256;
	localparam int CYCLE_LIMIT = 100000;  // a clean run stays well under this limit

	// One expected result: the entry read (zero unless valid), count and status.
	typedef struct packed {
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] sym;
		logic       valid;
		logic [8:0] count;
		status_t    st;
	} deque_result_t;

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       start       = 1'b0;
	logic [2:0] cmd         = '0;
	logic [7:0] pos_x       = '0;
	logic [7:0] pos_y       = '0;
	logic [7:0] pos_symbol  = '0;
	logic [7:0] item_index  = '0;
	logic       busy;
	logic       done;
	logic [7:0] out_x;
	logic [7:0] out_y;
	logic [7:0] out_symbol;
	logic       out_valid;
	logic [8:0] entry_count;
	logic [1:0] status;

	// Shadow of the ring: entries by slot, head slot and entry count.
	logic [23:0]   shadow_ring [DEPTH];
	logic [7:0]    shadow_head  = '0;
	logic [8:0]    shadow_count = '0;

	deque_result_t pending_results[$];  // one per accepted command, oldest first
	int            mismatch_count = 0;
	int            cycle_count    = 0;
	bit            no_idle        = 1'b0;  // set for stretches of back-to-back transfers

	bounded_position_deque #(
		.CAPACITY  (DEPTH),
		.COORD_BITS(8)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_symbol (pos_symbol),
		.item_index (item_index),
		.done       (done),
		.out_x      (out_x),
		.out_y      (out_y),
		.out_symbol (out_symbol),
		.out_valid  (out_valid),
		.entry_count(entry_count),
		.status     (status)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Applies one command to the shadow ring and returns the result it must give.
	// Head inserts step the head back one slot; tail inserts land at head + count.
	function automatic deque_result_t apply_deque_cmd(input cmd_t c, input logic [7:0] x,
			input logic [7:0] y, input logic [7:0] s, input logic [7:0] idx);
		deque_result_t r;
		logic [7:0]    slot;
		r    = '0;
		r.st = ST_OK;
		case (c)
			CMD_INS_HEAD, CMD_INS_TAIL: begin
				if (shadow_count == DEPTH) begin
					r.st = ST_FULL;  // dropped, nothing moves
				end else begin
					if (c == CMD_INS_HEAD) begin
						shadow_head = shadow_head - 8'd1;
						slot        = shadow_head;
					end else begin
						slot = shadow_head + shadow_count[7:0];
					end
					shadow_ring[slot] = {x, y, s};
					shadow_count      = shadow_count + 9'd1;
				end
			end
			CMD_RM_HEAD, CMD_RM_TAIL: begin
				if (shadow_count == 0) begin
					r.st = ST_EMPTY;
				end else begin
					if (c == CMD_RM_HEAD)
						shadow_head = shadow_head + 8'd1;
					shadow_count = shadow_count - 9'd1;
				end
			end
			CMD_RD_HEAD, CMD_RD_TAIL: begin
				if (shadow_count == 0) begin
					r.st = ST_BAD_INDEX;
				end else begin
					slot = (c == CMD_RD_HEAD) ? shadow_head
						: shadow_head + 8'(shadow_count - 9'd1);
					{r.x, r.y, r.sym} = shadow_ring[slot];
					r.valid           = 1'b1;
				end
			end
			CMD_RD_INDEX: begin
				// an index equal to the count is already outside the list
				if ({1'b0, idx} >= shadow_count) begin
					r.st = ST_BAD_INDEX;
				end else begin
					slot              = shadow_head + idx;
					{r.x, r.y, r.sym} = shadow_ring[slot];
					r.valid           = 1'b1;
				end
			end
			default: ;  // count report only
		endcase
		r.count = shadow_count;
		return r;
	endfunction

	function automatic logic [7:0] rand8();
		return 8'($urandom);
	endfunction

	// Each cycle idles with a chance of 38 in a hundred.
	task automatic idle_gap();
		if (!no_idle) begin
			while ($urandom_range(99) < 38) begin
				start <= 1'b0;
				@(posedge clk);
			end
		end
	endtask

	// Presents one command and holds it until a transfer happens (start high, busy low).
	// Called just after a rising edge; start stays high for a following command unless an idle gap lowers it.
	task automatic send_cmd(input cmd_t c, input logic [7:0] x, input logic [7:0] y,
			input logic [7:0] s, input logic [7:0] idx);
		start      <= 1'b1;
		cmd        <= c;
		pos_x      <= x;
		pos_y      <= y;
		pos_symbol <= s;
		item_index <= idx;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		pending_results.push_back(apply_deque_cmd(c, x, y, s, idx));
		idle_gap();
	endtask

	task automatic send_rand(input cmd_t c, input logic [7:0] idx);
		send_cmd(c, rand8(), rand8(), rand8(), idx);
	endtask

	// An index that usually falls inside the list, sometimes anywhere.
	function automatic logic [7:0] pick_index();
		if (shadow_count != 0 && $urandom_range(99) < 85)
			return 8'($urandom_range(0, shadow_count - 1));
		return rand8();
	endfunction

	// Every remove and read on an empty list, plus the count report.
	task automatic test_empty_list();
		send_rand(CMD_RM_HEAD, rand8());
		send_rand(CMD_RM_TAIL, rand8());
		send_rand(CMD_RD_HEAD, rand8());
		send_rand(CMD_RD_TAIL, rand8());
		send_rand(CMD_RD_INDEX, 8'd0);
		send_rand(CMD_COUNT, 8'd255);
	endtask

	// Field extremes at both ends, head pointer wrapping below slot zero,
	// index reads at the count and at the top of the index range.
	task automatic test_end_extremes();
		send_cmd(CMD_INS_HEAD, 8'hFF, 8'h00, 8'hFF, 8'h00);
		send_cmd(CMD_INS_TAIL, 8'h00, 8'hFF, 8'h00, 8'hFF);
		send_cmd(CMD_INS_HEAD, 8'hAA, 8'h55, 8'h5A, 8'hA5);
		send_cmd(CMD_RD_HEAD, 8'h00, 8'h00, 8'h00, 8'h00);
		send_cmd(CMD_RD_TAIL, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_cmd(CMD_RD_INDEX, 8'h00, 8'h00, 8'h00, 8'd1);
		send_cmd(CMD_RD_INDEX, 8'h00, 8'h00, 8'h00, 8'd3);
		send_cmd(CMD_RD_INDEX, 8'h00, 8'h00, 8'h00, 8'd255);
		send_cmd(CMD_COUNT, 8'h00, 8'h00, 8'h00, 8'h00);
		send_rand(CMD_RM_TAIL, rand8());
		send_rand(CMD_RM_HEAD, rand8());
		send_rand(CMD_RD_TAIL, rand8());
		send_rand(CMD_RM_HEAD, rand8());
		send_rand(CMD_RM_HEAD, rand8());
	endtask

	// Fills the ring from both ends to capacity, hits it while full, reads the
	// last index, then drains it past empty. The first stretch runs without idling.
	task automatic test_fill_and_drain();
		int n;
		n       = 0;
		no_idle = 1'b1;
		while (shadow_count < DEPTH) begin
			if (n == 200)
				no_idle = 1'b0;
			if ($urandom_range(99) < 20)
				send_rand(cmd_t'(3'($urandom_range(CMD_RD_HEAD, CMD_RD_INDEX))),
					pick_index());
			else
				send_rand($urandom_range(1) ? CMD_INS_HEAD : CMD_INS_TAIL, rand8());
			n++;
		end
		no_idle = 1'b0;
		send_rand(CMD_INS_HEAD, rand8());
		send_rand(CMD_INS_TAIL, rand8());
		send_rand(CMD_RD_INDEX, 8'd255);
		send_rand(CMD_RD_INDEX, 8'd0);
		send_rand(CMD_RD_HEAD, rand8());
		send_rand(CMD_RD_TAIL, rand8());
		send_rand(CMD_COUNT, rand8());
		while (shadow_count != 0) begin
			if ($urandom_range(99) < 20)
				send_rand(CMD_RD_INDEX, pick_index());
			else
				send_rand($urandom_range(1) ? CMD_RM_HEAD : CMD_RM_TAIL, rand8());
		end
		send_rand(CMD_RM_TAIL, rand8());
		send_rand(CMD_RM_HEAD, rand8());
		send_rand(CMD_RD_INDEX, 8'd0);
	endtask

	// Random walk of the list level towards a target that moves every 150 commands.
	// Most commands push the level towards the target or read inside the list;
	// a few are fully random.
	task automatic test_random_walk(input int n_cmds);
		int target_level;
		int roll;
		target_level = 0;
		for (int i = 0; i < n_cmds; i++) begin
			if (i % 150 == 0)
				target_level = ($urandom_range(3) == 0) ? DEPTH : $urandom_range(0, DEPTH);
			no_idle = (i >= 600 && i < 800);
			roll    = $urandom_range(99);
			if (roll < 8) begin
				send_rand(cmd_t'(3'($urandom_range(7))), rand8());
			end else if (roll < 53) begin
				if ((shadow_count < target_level) == ($urandom_range(99) < 80))
					send_rand($urandom_range(1) ? CMD_INS_HEAD : CMD_INS_TAIL, rand8());
				else
					send_rand($urandom_range(1) ? CMD_RM_HEAD : CMD_RM_TAIL, rand8());
			end else if (roll < 92) begin
				send_rand(cmd_t'(3'($urandom_range(CMD_RD_HEAD, CMD_RD_INDEX))),
					pick_index());
			end else begin
				send_rand(CMD_COUNT, rand8());
			end
		end
		no_idle = 1'b0;
	endtask

	// Result checker: every done cycle carries one result and must match the oldest
	// expectation, field by field.
	always @(posedge clk) begin : check_results
		deque_result_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: result with nothing expected: x=%h y=%h sym=%h v=%b n=%0d st=%0d",
						$realtime, out_x, out_y, out_symbol, out_valid, entry_count, status);
			end else begin
				want = pending_results.pop_front();
				if (out_x !== want.x || out_y !== want.y || out_symbol !== want.sym
						|| out_valid !== want.valid || entry_count !== want.count
						|| status !== want.st) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display({"%0t: mismatch: expected x=%h y=%h sym=%h v=%b n=%0d st=%0d,",
							" got x=%h y=%h sym=%h v=%b n=%0d st=%0d"}, $realtime,
							want.x, want.y, want.sym, want.valid, want.count, want.st,
							out_x, out_y, out_symbol, out_valid, entry_count, status);
				end
			end
		end
	end

	// Watchdog on the whole run.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_bounded_position_deque: FAIL");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_list();
		test_end_extremes();
		test_fill_and_drain();
		test_random_walk(1300);
		start <= 1'b0;
		// wait until every outstanding result has been checked
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_bounded_position_deque: PASS");
		else
			$display("tb_bounded_position_deque: FAIL");
		$finish;
	end

endmodule
